>>> rtl/core/pidwd_pkg.sv
// shared types and constants for the windowed-derivative pid regulator
package pidwd_pkg;

	// serial divider sizes: dividend covers the scaled derivative numerator
	localparam int DIV_W  = 49;
	localparam int DVS_W  = 21;
	localparam int DCNT_W = 6;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_INT_GAIN      = 3'd1,
		REG_DERIV_GAIN    = 3'd2,
		REG_SAMPLE_PERIOD = 3'd3,
		REG_WINDUP_LIMIT  = 3'd4,
		REG_TARGET        = 3'd5,
		REG_HISTORY_LEN   = 3'd6
	} reg_idx_t;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_HWR    = 14'b00000000000010,
		S_IACC   = 14'b00000000000100,
		S_PROP   = 14'b00000000001000,
		S_DEN    = 14'b00000000010000,
		S_DNUM   = 14'b00000000100000,
		S_ILO    = 14'b00000001000000,
		S_IHI    = 14'b00000010000000,
		S_CLAMP  = 14'b00000100000000,
		S_CDIV   = 14'b00001000000000,
		S_RELOAD = 14'b00010000000000,
		S_ITERM  = 14'b00100000000000,
		S_DDIV   = 14'b01000000000000,
		S_OUT    = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

endpackage

>>> rtl/core/pidwd_div.sv
// unsigned restoring divider, one quotient bit per cycle
module pidwd_div import pidwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0] sh;
	logic [DVS_W+1:0] trial;

	assign sh = {rem_q, quo_q[DIV_W-1]};
	assign trial = {1'b0, sh} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			// keep the shifted remainder only when the trial subtract went negative
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W-1:0];
			end else begin
				rem_q <= sh[DVS_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], ~trial[DVS_W+1]};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/pid_regulator_windowed_derivative.sv
// pid regulator with windowed derivative and anti-windup clamp, top level
// sample path: history write, integral accumulate, proportional, derivative denominator and
// numerator, integral product, optional clamp divide and reload, optional derivative divide
// one item at a time: no new input until the result is out; serial divider and 17x26 multiplier
// a clear transaction gives no result; a stalled result holds the input
// reset: config registers take their reset values, integrator and history read zero
module pid_regulator_windowed_derivative import pidwd_pkg::*; #(
	parameter int MAX_HISTORY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic signed [15:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] drive,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [30:0] cfg_data
);

	localparam int PW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;

	state_t state_q;

	logic signed [15:0] pg_q, ig_q, dg_q, tgt_q;
	logic [15:0] sp_q;
	logic [30:0] windup_q;
	logic [4:0] hlen_q;

	logic signed [16:0] last_err_q;
	logic signed [47:0] acc_q;
	logic [PW-1:0] pos_q;
	logic [MAX_HISTORY-1:0] vld_q;
	logic clamped_q;
	logic qneg_q;
	logic out_valid_q;
	logic signed [31:0] drive_q;

	logic signed [16:0] e_q;
	logic signed [42:0] mp_q;
	logic signed [17:0] diff_q;
	logic [DVS_W-1:0] den_q;
	logic signed [33:0] dnum_q;
	logic signed [63:0] prod_q;
	logic signed [51:0] sum_q;
	logic signed [16:0] hist_mem [MAX_HISTORY];
	logic signed [16:0] rd_q;
	logic rd_vld_q;

	logic [4:0] n_len, n_new;
	logic [PW:0] pos_inc;
	logic [PW-1:0] nxt_pos;
	logic signed [16:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [23:0] acc_hi;
	logic signed [48:0] acc_sum;
	logic signed [47:0] acc_sat;
	logic signed [63:0] lim64;
	logic clamp_hi, clamp_lo, do_clamp;
	logic signed [63:0] prod_adj;
	logic signed [47:0] it_term;
	logic [16:0] ig_abs;
	logic signed [33:0] dnum_abs;
	logic signed [16:0] hist;
	div_req_t div_req;
	logic div_done;
	logic [DIV_W-1:0] div_q;
	logic signed [51:0] dq_ext;
	logic accept_in;

	assign n_len = (32'(hlen_q) > MAX_HISTORY) ? 5'(MAX_HISTORY) : hlen_q;
	assign n_new = (32'(cfg_data[4:0]) > MAX_HISTORY) ? 5'(MAX_HISTORY) : cfg_data[4:0];
	assign pos_inc = {1'b0, pos_q} + 1'b1;
	assign nxt_pos = (32'(pos_inc) >= 32'(n_len)) ? '0 : pos_inc[PW-1:0];

	assign acc_hi = acc_q[47:24];
	assign acc_sum = 49'(acc_q) + 49'(mp_q);
	assign acc_sat = (acc_sum[48] != acc_sum[47]) ?
		(acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : acc_sum[47:0];

	assign lim64 = {17'b0, windup_q, 16'b0};
	assign clamp_hi = prod_q > lim64;
	assign clamp_lo = prod_q < -lim64;
	assign do_clamp = !clamped_q && (n_len != 5'd0) && (ig_q != 16'sd0) && (clamp_hi || clamp_lo);

	// integral term truncated toward zero
	assign prod_adj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
	assign it_term = prod_adj[63:16];

	assign ig_abs = ig_q[15] ? 17'(-17'(ig_q)) : 17'(ig_q);
	assign dnum_abs = dnum_q[33] ? -dnum_q : dnum_q;
	assign hist = rd_vld_q ? rd_q : 17'sd0;
	assign dq_ext = {3'b0, div_q};

	assign in_ready = (state_q == S_IDLE);
	assign accept_in = in_valid && in_ready;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign drive = drive_q;

	// operand select for the shared multiplier, product lands in mp_q next cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_HWR: begin
				mul_a = {1'b0, sp_q};
				mul_b = 26'(e_q);
			end
			S_IACC: begin
				mul_a = 17'(pg_q);
				mul_b = 26'(e_q);
			end
			S_PROP: begin
				mul_a = {1'b0, sp_q};
				mul_b = {21'b0, n_len};
			end
			S_DEN: begin
				mul_a = 17'(dg_q);
				mul_b = 26'(diff_q);
			end
			S_DNUM, S_RELOAD: begin
				mul_a = 17'(ig_q);
				mul_b = {2'b0, acc_q[23:0]};
			end
			S_ILO: begin
				mul_a = 17'(ig_q);
				mul_b = 26'(acc_hi);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = '0;
		if (state_q == S_CLAMP && do_clamp) begin
			div_req.start = 1'b1;
			div_req.dividend = {2'b0, windup_q, 16'b0};
			div_req.divisor = DVS_W'(ig_abs);
		end else if (state_q == S_ITERM && n_len != 5'd0 && den_q != '0) begin
			div_req.start = 1'b1;
			div_req.dividend = {dnum_abs[32:0], 16'b0};
			div_req.divisor = den_q;
		end
	end

	pidwd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pg_q <= '0;
			ig_q <= '0;
			dg_q <= '0;
			sp_q <= 16'd656;
			windup_q <= '1;
			tgt_q <= '0;
			hlen_q <= '0;
			last_err_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
			vld_q <= '0;
			clamped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PROP_GAIN:     pg_q <= cfg_data[15:0];
					REG_INT_GAIN:      ig_q <= cfg_data[15:0];
					REG_DERIV_GAIN:    dg_q <= cfg_data[15:0];
					REG_SAMPLE_PERIOD: sp_q <= cfg_data[15:0];
					REG_WINDUP_LIMIT:  windup_q <= cfg_data;
					REG_TARGET:        tgt_q <= cfg_data[15:0];
					REG_HISTORY_LEN: begin
						hlen_q <= cfg_data[4:0];
						pos_q <= (n_new != 5'd0) ? PW'(n_new - 5'd1) : '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						clamped_q <= 1'b0;
						if (func) begin
							acc_q <= '0;
							last_err_q <= '0;
							vld_q <= '0;
						end else begin
							state_q <= S_HWR;
						end
					end
				end
				S_HWR: begin
					if (n_len != 5'd0) begin
						pos_q <= nxt_pos;
						vld_q[nxt_pos] <= 1'b1;
					end
					last_err_q <= e_q;
					state_q <= S_IACC;
				end
				S_IACC: begin
					acc_q <= acc_sat;
					state_q <= S_PROP;
				end
				S_PROP:  state_q <= S_DEN;
				S_DEN:   state_q <= S_DNUM;
				S_DNUM:  state_q <= S_ILO;
				S_ILO:   state_q <= S_IHI;
				S_IHI:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= do_clamp ? S_CDIV : S_ITERM;
				S_CDIV: begin
					if (div_done) begin
						acc_q <= qneg_q ? -48'(div_q) : 48'(div_q);
						clamped_q <= 1'b1;
						state_q <= S_RELOAD;
					end
				end
				S_RELOAD: state_q <= S_ILO;
				S_ITERM: state_q <= div_req.start ? S_DDIV : S_OUT;
				S_DDIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mp_q <= mul_a * mul_b;
		if (accept_in) begin
			e_q <= 17'(tgt_q) - 17'(sample);
		end
		if (state_q == S_HWR && n_len != 5'd0) begin
			hist_mem[nxt_pos] <= last_err_q;
		end
		if (state_q == S_IACC) begin
			rd_q <= hist_mem[nxt_pos];
			rd_vld_q <= vld_q[nxt_pos];
		end
		unique case (state_q)
			S_PROP: begin
				sum_q <= 52'(mp_q);
				diff_q <= 18'(e_q) - 18'(hist);
			end
			S_DEN:  den_q <= mp_q[DVS_W-1:0];
			S_DNUM: dnum_q <= mp_q[33:0];
			S_ILO:  prod_q <= 64'(mp_q);
			S_IHI:  prod_q <= prod_q + (64'(mp_q) <<< 24);
			S_CLAMP: begin
				qneg_q <= clamp_hi ? ig_q[15] : !ig_q[15];
			end
			S_ITERM: begin
				sum_q <= sum_q + 52'(it_term);
				qneg_q <= dnum_q[33];
			end
			S_DDIV: begin
				if (div_done) begin
					sum_q <= qneg_q ? sum_q - dq_ext : sum_q + dq_ext;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					if (sum_q[51:31] != {21{sum_q[51]}}) begin
						drive_q <= sum_q[51] ? 32'sh80000000 : 32'sh7fffffff;
					end else begin
						drive_q <= sum_q[31:0];
					end
				end
			end
			default: ;
		endcase
	end

	a_div_start_place: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == S_CLAMP || state_q == S_ITERM))
		else $error("divider started outside clamp or derivative step");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(n_len != 5'd0 && !(cfg_valid && cfg_index == REG_HISTORY_LEN)) |=>
		(n_len == 5'd0 || 32'(pos_q) < 32'(n_len)))
		else $error("ring position outside history window");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && !func) |=> state_q == S_HWR)
		else $error("sample transaction did not start the sequence");

	a_clamp_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLAMP && clamped_q) |=> state_q == S_ITERM)
		else $error("windup clamp applied twice for one sample");

	a_cdiv_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CDIV && div_done) |=> state_q == S_RELOAD)
		else $error("clamp divide did not reload the integral product");

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the windowed-derivative pid regulator
module tb_top import pidwd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_MAX = 16;
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;
	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -ACC_HI - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [15:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	// predictor state
	longint kp, ki, kd, setpoint;
	longint period, wlimit, hlen;
	longint prev_err, integ;
	int unsigned ring_pos;
	longint err_ring [HIST_MAX];

	logic signed [31:0] drive_q [$];
	int n_err = 0;
	bit rx_idle_on = 1'b1;
	bit tx_idle_on = 1'b1;
	bit rx_hold = 1'b0;

	pid_regulator_windowed_derivative i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sx(longint v, int w);
		longint m;
		m = 64'sd1 <<< (w - 1);
		v = v & ((m <<< 1) - 1);
		return (v ^ m) - m;
	endfunction

	function automatic int unsigned win_len();
		return (hlen > HIST_MAX) ? HIST_MAX : int'(hlen);
	endfunction

	function automatic int unsigned ring_next(int unsigned p, int unsigned n);
		return (p + 1 >= n) ? 0 : p + 1;
	endfunction

	function automatic void pid_reg_write(reg_idx_t idx, longint v);
		int unsigned n;
		case (idx)
			REG_PROP_GAIN: kp = sx(v, 16);
			REG_INT_GAIN: ki = sx(v, 16);
			REG_DERIV_GAIN: kd = sx(v, 16);
			REG_SAMPLE_PERIOD: period = v & 64'hFFFF;
			REG_WINDUP_LIMIT: wlimit = v & 64'h7FFFFFFF;
			REG_TARGET: setpoint = sx(v, 16);
			REG_HISTORY_LEN: begin
				hlen = v & 31;
				n = win_len();
				ring_pos = n ? n - 1 : 0;
			end
			default: ;
		endcase
	endfunction

	// returns 1 and the expected drive when the transaction gives a result
	function automatic bit pid_drive(logic f, logic signed [15:0] s,
			output logic signed [31:0] y);
		int unsigned n;
		longint e, acc, it, d, sum, prod, lim, diff, den;
		n = win_len();
		d = 0;
		y = '0;
		if (f == FUNC_CLEAR) begin
			integ = 0;
			prev_err = 0;
			foreach (err_ring[i]) err_ring[i] = 0;
			return 1'b0;
		end
		e = setpoint - longint'(s);
		if (n) begin
			ring_pos = ring_next(ring_pos, n);
			err_ring[ring_pos] = prev_err;
		end
		prev_err = e;
		acc = integ + e * period;
		if (acc > ACC_HI) acc = ACC_HI;
		if (acc < ACC_LO) acc = ACC_LO;
		integ = acc;
		if (n && ki != 0) begin
			prod = ki * integ;
			lim = wlimit * 65536;
			if (prod > lim) integ = lim / ki;
			else if (prod < -lim) integ = -lim / ki;
		end
		it = (ki * integ) / 65536;
		if (n) begin
			diff = e - err_ring[ring_next(ring_pos, n)];
			den = period * longint'(n);
			if (den != 0) d = (kd * diff * 65536) / den;
		end
		sum = kp * e + it + d;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		y = sum[31:0];
		return 1'b1;
	endfunction

	// valid stays up after acceptance until the next item or tx_stop replaces it
	task automatic send_item(logic f, logic signed [15:0] s);
		logic signed [31:0] y;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		if (pid_drive(f, s, y)) drive_q.push_back(y);
	endtask

	task automatic tx_stop();
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		tx_stop();
		while (drive_q.size() != 0) @(posedge clk);
		// the block may still be busy on a trailing clear or the last divide
		repeat (130) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, longint v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[30:0];
		do @(posedge clk); while (!cfg_ready);
		pid_reg_write(idx, v);
	endtask

	task automatic set_all(longint p, longint i, longint dg, longint per, longint lim,
			longint tg, longint hl);
		drain();
		reg_write(REG_PROP_GAIN, p);
		reg_write(REG_INT_GAIN, i);
		reg_write(REG_DERIV_GAIN, dg);
		reg_write(REG_SAMPLE_PERIOD, per);
		reg_write(REG_WINDUP_LIMIT, lim);
		reg_write(REG_TARGET, tg);
		reg_write(REG_HISTORY_LEN, hl);
		cfg_valid <= 1'b0;
	endtask

	task automatic rand_cfg();
		longint lim;
		case ($urandom_range(0, 2))
			0: lim = longint'($urandom_range(0, 1000));
			1: lim = longint'($urandom_range(0, 32'h7FFFFFFF));
			default: lim = 32'h7FFFFFFF;
		endcase
		set_all(longint'($urandom_range(0, 65535)), longint'($urandom_range(0, 65535)),
			longint'($urandom_range(0, 65535)), longint'($urandom_range(0, 65535)), lim,
			longint'($urandom_range(0, 65535)), longint'($urandom_range(0, 31)));
	endtask

	task automatic test_directed();
		// reset settings first: no derivative, no clamp
		send_item(FUNC_SAMPLE, 16'sh7FFF);
		send_item(FUNC_SAMPLE, -16'sh8000);
		set_all(32767, -32768, 32767, 65535, 0, -32768, 16);
		send_item(FUNC_SAMPLE, 16'sh7FFF);
		send_item(FUNC_SAMPLE, -16'sh8000);
		send_item(FUNC_CLEAR, 16'sh1234);
		send_item(FUNC_SAMPLE, 16'sh0000);
		// oversize history length acts as the maximum
		set_all(-32768, 32767, -32768, 1, 32'h7FFFFFFF, 32767, 31);
		repeat (4) send_item(FUNC_SAMPLE, -16'sh8000);
		// integrator growth without clamp, history length zero
		set_all(1, 32767, 0, 65535, 32'h7FFFFFFF, 32767, 0);
		repeat (6) send_item(FUNC_SAMPLE, -16'sh8000);
		// zero period divisor, history of one
		set_all(256, 256, 256, 0, 100, 5, 1);
		send_item(FUNC_SAMPLE, 16'sh0003);
		send_item(FUNC_SAMPLE, -16'sh0003);
		send_item(FUNC_CLEAR, 16'sh0000);
		send_item(FUNC_SAMPLE, 16'sh7FFF);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			rand_cfg();
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 30) == 0) send_item(FUNC_CLEAR, 16'($urandom));
				else if ($urandom_range(0, 3) == 0) send_item(FUNC_SAMPLE, 16'($urandom));
				else send_item(FUNC_SAMPLE, 16'($urandom_range(0, 400)) - 16'sd200);
			end
		end
	endtask

	task automatic test_backpressure();
		rand_cfg();
		rx_hold = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			repeat (6) send_item(FUNC_SAMPLE, 16'($urandom));
		join
		tx_stop();
		// sender waits until everything has come back
		while (drive_q.size() != 0) @(posedge clk);
		repeat (5) send_item(FUNC_SAMPLE, 16'($urandom));
	endtask

	task automatic test_no_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rand_cfg();
		repeat (100) send_item(FUNC_SAMPLE, 16'($urandom));
	endtask

	// result side: random stalls and checking of each result
	initial begin
		int gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					$display("%0t unexpected drive %0d", $realtime, drive);
					n_err++;
				end else begin
					logic signed [31:0] exp_d;
					exp_d = drive_q.pop_front();
					if (drive !== exp_d) begin
						$display("%0t drive mismatch exp %0d got %0d", $realtime,
							exp_d, drive);
						n_err++;
					end
				end
			end
			if (gap > 0) gap--;
			else if (rx_idle_on && $urandom_range(0, 6) == 0)
				gap = $urandom_range(1, 19);
			out_ready <= !rx_hold && gap == 0;
		end
	end

	initial begin
		kp = 0; ki = 0; kd = 0; setpoint = 0;
		period = 656; wlimit = 64'h7FFFFFFF; hlen = 0;
		prev_err = 0; integ = 0; ring_pos = 0;
		foreach (err_ring[i]) err_ring[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_no_idle();
		tx_stop();
		while (drive_q.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
		if (n_err == 0 && drive_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb_top: errors");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/pidwd_pkg.sv
rtl/core/pidwd_div.sv
rtl/core/pid_regulator_windowed_derivative.sv
verif/tb_top.sv
